// File: src/fletv_pkg.sv
`timescale 1ns / 1ps
// Package for the Fletcher trailer verifier: beat types, command and kind codes.
// No dependencies; imported by every module of the block.
package fletv_pkg;

    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_PUSH = 2'd2;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_RETURN  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       checksum_ok;
        logic       last;
    } t_out_beat;

    // Up to two results per input beat, r0 first.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_beat  r0;
        t_out_beat  r1;
    } t_res_pair;

endpackage

// File: src/fletcher_trailer_verifier_unit.sv
`timescale 1ns / 1ps
// Fletcher trailer verifier, top level. Uses fletv_pkg, fletv_core, fletv_outq.
// Beats pass the input register and core into the queue. Throughput: one input beat per
// cycle while the queue has room for two results; an end beat that also flushes a lone
// held byte makes two results; the output drains one result per cycle unless stalled.
// Reset (synchronous, active low): window bytes 255, sums 0, need-two phase, queue empty.
module fletcher_trailer_verifier_unit
    import fletv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    // input register stage
    logic      r_in_valid, n_in_valid;
    t_in_beat  r_in_beat;

    logic      accept;
    logic      go;
    logic      room;
    t_res_pair res;

    // The held beat is processed once the queue can absorb two results.
    assign go         = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_beat <= i_in_beat;
        end
    end

    // window, sums and per-beat results
    fletv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_beat  (r_in_beat),
        .o_res   (res)
    );

    // result queue separates the output handshake from the input side
    fletv_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (go),
        .i_res       (res),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

// File: src/fletv_core.sv
`timescale 1ns / 1ps
// Window, running sums and result generation for one input beat.
// Depends on fletv_pkg.
module fletv_core
    import fletv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_beat  i_beat,
    output t_res_pair o_res
);

    localparam logic [1:0] PH_NEED2  = 2'd0;
    localparam logic [1:0] PH_NEED1  = 2'd1;
    localparam logic [1:0] PH_STREAM = 2'd2;
    localparam logic [1:0] PH_ENDED  = 2'd3;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_old, n_old;
    logic [7:0] r_mid, n_mid;
    logic [7:0] r_new, n_new;
    logic [7:0] r_sum1, n_sum1;
    logic [7:0] r_sum2, n_sum2;

    logic [7:0] add1, add2;
    logic       match;

    assign add1  = r_sum1 + r_mid;
    assign add2  = r_sum2 + add1;
    assign match = (r_mid == r_sum1) && (r_new == r_sum2);

    always_comb begin
        n_phase = r_phase;
        n_old   = r_old;
        n_mid   = r_mid;
        n_new   = r_new;
        n_sum1  = r_sum1;
        n_sum2  = r_sum2;
        o_res   = '0;
        case (i_beat.command)
            CMD_DATA: begin
                case (r_phase)
                    PH_NEED2: begin
                        n_new   = i_beat.data_byte;
                        n_phase = PH_NEED1;
                    end
                    PH_NEED1: begin
                        n_mid   = r_new;
                        n_new   = i_beat.data_byte;
                        n_phase = PH_STREAM;
                    end
                    PH_STREAM: begin
                        n_old  = r_mid;
                        n_mid  = r_new;
                        n_new  = i_beat.data_byte;
                        n_sum1 = add1;
                        n_sum2 = add2;
                        o_res.cnt         = 2'd1;
                        o_res.r0.kind     = KIND_DATA;
                        o_res.r0.out_byte = r_mid;
                        o_res.r0.last     = 1'b1;
                    end
                    default: begin
                        // bytes after the end are dropped
                    end
                endcase
            end
            CMD_END: begin
                n_phase = PH_ENDED;
                if (r_phase == PH_NEED1) begin
                    // lone held byte goes out first, sums untouched
                    o_res.cnt            = 2'd2;
                    o_res.r0.kind        = KIND_DATA;
                    o_res.r0.out_byte    = r_new;
                    o_res.r1.kind        = KIND_VERDICT;
                    o_res.r1.checksum_ok = match;
                    o_res.r1.last        = 1'b1;
                end else begin
                    o_res.cnt            = 2'd1;
                    o_res.r0.kind        = KIND_VERDICT;
                    o_res.r0.checksum_ok = match;
                    o_res.r0.last        = 1'b1;
                end
            end
            CMD_PUSH: begin
                o_res.cnt         = 2'd1;
                o_res.r0.kind     = KIND_RETURN;
                o_res.r0.out_byte = r_new;
                o_res.r0.last     = 1'b1;
                n_new  = r_mid;
                n_mid  = r_old;
                n_old  = i_beat.data_byte;
                n_sum2 = r_sum2 - r_sum1;
                n_sum1 = r_sum1 - i_beat.data_byte;
            end
            default: begin
                // unknown command: no effect
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NEED2;
            r_old   <= 8'hFF;
            r_mid   <= 8'hFF;
            r_new   <= 8'hFF;
            r_sum1  <= 8'h00;
            r_sum2  <= 8'h00;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_old   <= n_old;
            r_mid   <= n_mid;
            r_new   <= n_new;
            r_sum1  <= n_sum1;
            r_sum2  <= n_sum2;
        end
    end

endmodule

// File: src/fletv_outq.sv
`timescale 1ns / 1ps
// Four-entry result queue: takes up to two beats per cycle, gives one unless stalled.
// Depends on fletv_pkg.
module fletv_outq
    import fletv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_pair i_res,
    output logic      o_room,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_out_beat  r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] n_in;
    logic       pop;
    logic [1:0] wp1;

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_beat  = r_mem[r_rp];
    assign o_room      = (r_cnt <= 3'd2);
    assign pop         = o_out_valid && !i_out_stall;
    assign n_in        = i_push ? i_res.cnt : 2'd0;
    assign wp1         = r_wp + 2'd1;
    assign n_wp        = r_wp + n_in;
    assign n_rp        = r_rp + {1'b0, pop};
    assign n_cnt       = r_cnt + {1'b0, n_in} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (n_in != 2'd0) begin
            r_mem[r_wp] <= i_res.r0;
        end
        if (n_in == 2'd2) begin
            r_mem[wp1] <= i_res.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
